// ===== rtl/core/ebmlid_pkg.sv =====
`default_nettype none

package ebmlid_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 29;
  localparam int unsigned LengthW = 4;
  localparam int unsigned RemW    = 3;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_LEAD = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_e;

  localparam logic [ValueW-1:0] Id1Lo = ValueW'(32'h0000_0080);
  localparam logic [ValueW-1:0] Id1Hi = ValueW'(32'h0000_00FE);
  localparam logic [ValueW-1:0] Id2Lo = ValueW'(32'h0000_4000);
  localparam logic [ValueW-1:0] Id2Hi = ValueW'(32'h0000_7FFE);
  localparam logic [ValueW-1:0] Id3Lo = ValueW'(32'h0020_0000);
  localparam logic [ValueW-1:0] Id3Hi = ValueW'(32'h003F_FFFE);
  localparam logic [ValueW-1:0] Id4Lo = ValueW'(32'h1000_0000);
  localparam logic [ValueW-1:0] Id4Hi = ValueW'(32'h1FFF_FFFE);

  localparam logic [LengthW-1:0] MaxValidLen = LengthW'(4);

  // ID length from the position of the leading one; 0 for a zero byte
  function automatic logic [LengthW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LengthW-1:0] len;
    len = '0;
    if      (b[7]) len = LengthW'(1);
    else if (b[6]) len = LengthW'(2);
    else if (b[5]) len = LengthW'(3);
    else if (b[4]) len = LengthW'(4);
    else if (b[3]) len = LengthW'(5);
    else if (b[2]) len = LengthW'(6);
    else if (b[1]) len = LengthW'(7);
    else if (b[0]) len = LengthW'(8);
    return len;
  endfunction

  function automatic logic id_allowed(input logic [ValueW-1:0] v);
    return (v >= Id1Lo && v <= Id1Hi) ||
           (v >= Id2Lo && v <= Id2Hi) ||
           (v >= Id3Lo && v <= Id3Hi) ||
           (v >= Id4Lo && v <= Id4Hi);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ebml_id_stream_decoder_unit.sv =====
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_stall_o   data_byte_i[7:0]
// out       out  out_valid_o/out_stall_i id_value_o[28:0], id_length_o[3:0], status_o[1:0]
//
// One byte is taken per cycle unless stalled; the result appears in the
// output register the cycle after the last byte of an ID (or after a zero leading byte).
// A byte passes through the length decode and range compare combinationally.
// Reset clears the gather state and the output valid; no result is pending.
// in_stall_o rises only while a result is held and out_stall_i is high.

module ebml_id_stream_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ebmlid_pkg::ByteW-1:0]    data_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [ebmlid_pkg::ValueW-1:0]        id_value_o,
  output logic [ebmlid_pkg::LengthW-1:0]       id_length_o,
  output logic [1:0]                           status_o
);
  import ebmlid_pkg::*;

  logic                busy_q, busy_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [LengthW-1:0]  tot_q, tot_d;

  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [LengthW-1:0]  length_q, length_d;
  status_e             status_q, status_d;

  logic                in_xfer;
  logic                out_xfer;
  logic                emit;
  logic [LengthW-1:0]  lead_len;
  logic [ValueW-1:0]   fin_value;
  logic [LengthW-1:0]  fin_len;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;
  assign lead_len   = lead_length(data_byte_i);

  always_comb begin
    busy_d    = busy_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    tot_d     = tot_q;
    emit      = 1'b0;
    fin_value = acc_q;
    fin_len   = tot_q;
    value_d   = value_q;
    length_d  = length_q;
    status_d  = status_q;

    if (in_xfer) begin
      if (!busy_q) begin
        if (lead_len == '0) begin
          emit     = 1'b1;
          value_d  = '0;
          length_d = LengthW'(1);
          status_d = STATUS_ZERO_LEAD;
        end else begin
          acc_d = ValueW'(data_byte_i);
          tot_d = lead_len;
          rem_d = RemW'(lead_len - LengthW'(1));
          if (rem_d == '0) begin
            emit = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
      end else begin
        // shift the byte in; long IDs lose their top bits, they fail anyway
        acc_d = {acc_q[ValueW-ByteW-1:0], data_byte_i};
        rem_d = rem_q - RemW'(1);
        if (rem_d == '0) begin
          emit   = 1'b1;
          busy_d = 1'b0;
        end
      end

      fin_value = acc_d;
      fin_len   = tot_d;
      if (emit && lead_len != '0 || emit && busy_q) begin
        length_d = fin_len;
        if (fin_len <= MaxValidLen && id_allowed(fin_value)) begin
          value_d  = fin_value;
          status_d = STATUS_OK;
        end else begin
          value_d  = '0;
          status_d = STATUS_RANGE;
        end
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      acc_q       <= '0;
      rem_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload: no reset, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q  <= value_d;
      length_q <= length_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign id_value_o  = value_q;
  assign id_length_o = length_q;
  assign status_o    = status_q;

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0 && tot_q >= LengthW'(2)))
    else $error("gathering with no bytes left");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> (id_value_o == '0))
    else $error("error result carries a nonzero value");

  a_zero_lead_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_ZERO_LEAD) |-> (id_length_o == LengthW'(1)))
    else $error("zero leading byte result with wrong length");

  a_ok_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_OK) |->
      (id_length_o >= LengthW'(1) && id_length_o <= MaxValidLen))
    else $error("valid ID with length beyond four bytes");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (($past(busy_q) == busy_q) && ($past(rem_q) == rem_q)))
    else $error("gather state moved while input stalled");

endmodule

`default_nettype wire

// ===== verif/id_decode_check_pkg.sv =====
package id_decode_check_pkg;

  import ebmlid_pkg::*;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [LengthW-1:0] length;
    status_e            status;
  } id_result_t;

  // Tracks the ID being gathered and the decoded IDs still owed by the block.
  class id_stream_tracker;
    logic [31:0]        gathered;
    logic [RemW-1:0]    left;
    logic [LengthW-1:0] id_len;
    bit                 gathering;
    id_result_t         pending_ids[$];
    int unsigned        errors;
    int unsigned        agreed;
    int unsigned        per_status[3];

    function new();
      gathered   = '0;
      left       = '0;
      id_len     = '0;
      gathering  = 1'b0;
      errors     = 0;
      agreed     = 0;
      per_status = '{default: 0};
    endfunction

    // highest set bit wins: bit 7 gives one byte, bit 0 gives eight
    function logic [LengthW-1:0] marker_len(logic [ByteW-1:0] b);
      logic [LengthW-1:0] n;
      n = '0;
      for (int k = 0; k < ByteW; k++) begin
        if (b[k]) n = LengthW'(ByteW - k);
      end
      return n;
    endfunction

    function bit in_allowed_range(logic [31:0] v);
      return (v >= Id1Lo && v <= Id1Hi) || (v >= Id2Lo && v <= Id2Hi) ||
             (v >= Id3Lo && v <= Id3Hi) || (v >= Id4Lo && v <= Id4Hi);
    endfunction

    function void close_id();
      id_result_t r;
      gathering = 1'b0;
      left      = '0;
      r.length  = id_len;
      if (id_len >= 1 && id_len <= MaxValidLen && in_allowed_range(gathered)) begin
        r.value  = gathered[ValueW-1:0];
        r.status = STATUS_OK;
      end else begin
        r.value  = '0;
        r.status = STATUS_RANGE;
      end
      pending_ids.push_back(r);
    endfunction

    // Advance the ID state by one accepted byte.
    function void take_byte(logic [ByteW-1:0] b);
      id_result_t         r;
      logic [LengthW-1:0] n;
      if (!gathering) begin
        n = marker_len(b);
        if (n == '0) begin
          r.value  = '0;
          r.length = LengthW'(1);
          r.status = STATUS_ZERO_LEAD;
          pending_ids.push_back(r);
        end else begin
          gathered = {24'd0, b};
          id_len   = n;
          left     = RemW'(n - 1);
          if (left == '0) close_id();
          else gathering = 1'b1;
        end
      end else begin
        gathered = {gathered[23:0], b};
        left     = left - 1'b1;
        if (left == '0) close_id();
      end
    endfunction

    task report(string what);
      if (errors < 40) $display("[%0t] id mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [ValueW-1:0] v, logic [LengthW-1:0] l, logic [1:0] s);
      id_result_t want;
      bit         ok;
      if (pending_ids.size() == 0) begin
        report($sformatf("unexpected ID value %0h length %0d status %0d", v, l, s));
        return;
      end
      want = pending_ids.pop_front();
      ok   = 1'b1;
      if (v !== want.value) begin
        report($sformatf("value %0h, wanted %0h", v, want.value));
        ok = 1'b0;
      end
      if (l !== want.length) begin
        report($sformatf("length %0d, wanted %0d", l, want.length));
        ok = 1'b0;
      end
      if (s !== want.status) begin
        report($sformatf("status %0d, wanted %0d", s, want.status));
        ok = 1'b0;
      end
      if (ok) agreed++;
      per_status[int'(want.status)]++;
    endtask
  endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ebmlid_pkg::*;
  import id_decode_check_pkg::*;

  localparam logic [7:0] OPENING [23] = '{
    8'h00, 8'h80, 8'hFE, 8'hFF,
    8'h40, 8'h00, 8'h7F, 8'hFF,
    8'h3F, 8'hFF, 8'hFF,
    8'h1F, 8'hFF, 8'hFF, 8'hFE,
    8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [ValueW-1:0]  id_value_o;
  logic [LengthW-1:0] id_length_o;
  logic [1:0]         status_o;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;

  id_stream_tracker ids;

  ebml_id_stream_decoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .id_value_o  (id_value_o),
    .id_length_o (id_length_o),
    .status_o    (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ids.check_result(id_value_o, id_length_o, status_o);
    end
  end

  // Enter and leave on a falling edge; hold the byte until the transfer.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    ids.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // One well-formed ID of n bytes; n of zero sends a zero leading byte.
  task automatic send_id(input int unsigned n);
    logic [ByteW-1:0] mark;
    logic [ByteW-1:0] b;
    bit               all_ones;
    if (n == 0) begin
      send_byte('0);
    end else begin
      mark     = 8'h80 >> (n - 1);
      all_ones = ($urandom_range(7) == 0);
      b = all_ones ? (mark | (mark - 1'b1)) : (mark | (ByteW'($urandom) & (mark - 1'b1)));
      send_byte(b);
      for (int k = 1; k < n; k++) begin
        case ($urandom_range(9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = ByteW'($urandom);
        endcase
        if (all_ones) b = 8'hFF;
        send_byte(b);
      end
    end
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input int unsigned count);
    int unsigned target;
    int unsigned pick;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    target         = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 15)      send_byte(ByteW'($urandom));
      else if (pick < 20) send_id(0);
      else if (pick < 75) send_id($urandom_range(1, 4));
      else                send_id($urandom_range(5, 8));
    end
  endtask

  initial begin
    ids = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_gap_pct   = 10;
    recv_stall_pct = 66;
    foreach (OPENING[k]) send_byte(OPENING[k]);
    run_phase(10, 66, 230);
    run_phase(66, 10, 230);
    run_phase(0, 0, 240);
    in_valid_i <= 1'b0;
    while (ids.pending_ids.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("fed %0d bytes through three sender/receiver stall mixes", bytes_sent);
    $display("checked %0d IDs: %0d valid, %0d zero lead, %0d out of range",
             ids.per_status[0] + ids.per_status[1] + ids.per_status[2],
             ids.per_status[0], ids.per_status[1], ids.per_status[2]);
    if (ids.errors == 0) begin
      $display("ebml_id_stream_decoder_unit verification clean");
    end else begin
      $display("ebml_id_stream_decoder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("ebml_id_stream_decoder_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ebmlid_pkg.sv
rtl/core/ebml_id_stream_decoder_unit.sv
verif/id_decode_check_pkg.sv
verif/tb_top.sv
